// ===== src/bfla_pkg.sv =====
`default_nettype none

package bfla_pkg;

    // Address space held by the gap link store.
    localparam int SPACE_WORDS = 4096;
    localparam int SLOT_W      = $clog2(SPACE_WORDS);

    // Field widths.
    localparam int PLACE_W    = 12;
    localparam int SPACE_W    = 12;
    localparam int ENTRY_W    = 7;
    localparam int BUMP_W     = 13;
    localparam int COUNT_W    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    typedef logic [PLACE_W-1:0]    t_place;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [SPACE_W-1:0]    t_space;
    typedef logic [ENTRY_W-1:0]    t_entry;
    typedef logic [BUMP_W-1:0]     t_bump;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Register reset values.
    localparam t_space SPACE_SIZE_RST = 12'd4095;
    localparam t_entry ENTRY_SIZE_RST = 7'd8;

    // Live counters saturate here.
    localparam t_count COUNT_MAX = 12'hFFF;

    // Request codes.
    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    // Result status codes.
    typedef enum logic [0:0] {
        STATUS_OK       = 1'b0,
        STATUS_NO_SPACE = 1'b1
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACE_SIZE = 1'b0,
        CFG_ENTRY_SIZE = 1'b1
    } t_cfg_idx;

    // Control from the request stage to the gap list.
    typedef struct packed {
        logic   pop;
        logic   push;
        t_place place;
    } t_gap_ctl;

    // Status of the gap list seen by the request stage.
    typedef struct packed {
        t_place head;
    } t_gap_stat;

    // Store slot of an address: the address modulo the store depth.
    function automatic t_slot slot_of(t_place addr);
        return t_slot'(addr);
    endfunction

endpackage

`default_nettype wire

// ===== src/bfla_req_if.sv =====
`default_nettype none

interface bfla_req_if;
    logic               valid;
    logic               ready;
    logic [0:0]         command;
    bfla_pkg::t_place   place;
    logic [0:0]         is_node;

    modport source (output valid, output command, output place, output is_node, input ready);
    modport sink   (input valid, input command, input place, input is_node, output ready);
endinterface

`default_nettype wire

// ===== src/bfla_rsp_if.sv =====
`default_nettype none

interface bfla_rsp_if;
    logic               valid;
    logic               ready;
    bfla_pkg::t_place   given_place;
    logic [0:0]         status;
    bfla_pkg::t_count   nodes_live;
    bfla_pkg::t_count   links_live;

    modport source (output valid, output given_place, output status, output nodes_live,
                    output links_live, input ready);
    modport sink   (input valid, input given_place, input status, input nodes_live,
                    input links_live, output ready);
endinterface

`default_nettype wire

// ===== src/bfla_ram.sv =====
`default_nettype none

module bfla_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/bfla_gap_list.sv =====
`default_nettype none

module bfla_gap_list (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bfla_pkg::t_gap_ctl   i_ctl,
    output      bfla_pkg::t_gap_stat  o_stat
);

    bfla_pkg::t_place r_head;
    bfla_pkg::t_place n_head;
    bfla_pkg::t_place r_next;
    bfla_pkg::t_place n_next;
    logic             r_pend;
    logic             n_pend;
    bfla_pkg::t_place rd_link;
    bfla_pkg::t_place head_link;

    // The link of the current head: held in r_next, or still arriving from
    // the store in the cycle after a pop issued its read.
    assign head_link = r_pend ? rd_link : r_next;

    // Head and its link. A push knows the new head's link directly (the old
    // head); a pop starts a read of the link of the gap it exposes.
    always_comb begin
        n_head = r_head;
        n_next = r_next;
        n_pend = 1'b0;
        if (i_ctl.push) begin
            n_head = i_ctl.place;
            n_next = r_head;
        end else if (i_ctl.pop) begin
            n_head = head_link;
            n_pend = 1'b1;
        end else if (r_pend) begin
            n_next = rd_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_pend <= 1'b0;
        end else begin
            r_head <= n_head;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
    end

    // Link store: a push writes the old head at the freed slot.
    bfla_ram #(
        .WIDTH (bfla_pkg::PLACE_W),
        .DEPTH (bfla_pkg::SPACE_WORDS)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (bfla_pkg::slot_of(i_ctl.place)),
        .i_wdata (r_head),
        .i_re    (i_ctl.pop),
        .i_raddr (bfla_pkg::slot_of(head_link)),
        .o_rdata (rd_link)
    );

    assign o_stat.head = r_head;

endmodule

`default_nettype wire

// ===== src/bump_and_free_list_allocator.sv =====
`default_nettype none

// Fixed-size entry allocator with a gap list and a bump pointer.
// Requests arrive on i_req (command, place, is_node) and each one produces
// exactly one result beat on o_rsp (given_place, status, nodes_live,
// links_live), in order. A beat moves when valid and ready are both high.
// The request is captured in an input register; when the output register is
// free, the allocation decision, the gap list update and the counters are
// computed and the result is loaded into the output register, which shows it
// until it is taken. One request is taken every cycle while o_rsp is drained.
// A gap pop reads the next link from a one-read-port store; that read
// returns in the following cycle and is forwarded straight into the next pop.
// When the receiver stalls, the result holds, the input register holds one
// more request, and then i_req.ready drops until the result is taken.
// Configuration (space_size, entry_size) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data by the user only while the block is idle; not enforced.
// Synchronous reset empties the gap list, clears both counters, restores the
// register defaults and sets the bump pointer to the default entry size. The
// link store is not cleared and needs no clearing pass.
module bump_and_free_list_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    bfla_req_if.sink                             i_req,
    bfla_rsp_if.source                           o_rsp,
    input  wire logic                            i_cfg_we,
    input  wire logic [bfla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire bfla_pkg::t_cfg_data             i_cfg_data
);

    // Configuration registers.
    bfla_pkg::t_space r_space_size;
    bfla_pkg::t_entry r_entry_size;

    // Input register.
    logic             r_s1_valid;
    logic             r_s1_cmd;
    bfla_pkg::t_place r_s1_place;
    logic             r_s1_is_node;

    // Allocator state.
    bfla_pkg::t_bump  r_bump;
    bfla_pkg::t_bump  n_bump;
    bfla_pkg::t_count r_nodes;
    bfla_pkg::t_count n_nodes;
    bfla_pkg::t_count r_links;
    bfla_pkg::t_count n_links;

    // Output register.
    logic             r_out_valid;
    bfla_pkg::t_place r_out_given;
    logic             r_out_status;

    logic             s1_fire;
    logic             in_fire;
    logic             is_free;
    logic             has_gap;
    logic             fresh_ok;
    logic             no_space;
    logic             count_up;
    logic             count_dn;
    bfla_pkg::t_place n_given;
    logic             n_status;

    bfla_pkg::t_gap_ctl  gap_ctl;
    bfla_pkg::t_gap_stat gap_stat;

    // Handshake: the request stage moves when the output register is free.
    assign s1_fire     = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_req.valid && i_req.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_size <= bfla_pkg::SPACE_SIZE_RST;
            r_entry_size <= bfla_pkg::ENTRY_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (bfla_pkg::t_cfg_idx'(i_cfg_idx))
                bfla_pkg::CFG_SPACE_SIZE: begin
                    r_space_size <= i_cfg_data[bfla_pkg::SPACE_W-1:0];
                end
                bfla_pkg::CFG_ENTRY_SIZE: begin
                    r_entry_size <= i_cfg_data[bfla_pkg::ENTRY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd     <= i_req.command;
            r_s1_place   <= i_req.place;
            r_s1_is_node <= i_req.is_node;
        end
    end

    // Allocation decision: gap first, then a fresh entry, else no space.
    assign is_free  = (r_s1_cmd == bfla_pkg::CMD_FREE);
    assign has_gap  = (gap_stat.head != '0);
    assign fresh_ok = (r_bump < bfla_pkg::t_bump'(r_space_size));
    assign no_space = !is_free && !has_gap && !fresh_ok;

    assign gap_ctl.pop   = s1_fire && !is_free && has_gap;
    assign gap_ctl.push  = s1_fire && is_free;
    assign gap_ctl.place = r_s1_place;

    always_comb begin
        n_bump   = r_bump;
        n_given  = '0;
        n_status = bfla_pkg::STATUS_OK;
        if (!is_free) begin
            if (has_gap) begin
                n_given = gap_stat.head;
            end else if (fresh_ok) begin
                n_given = r_bump[bfla_pkg::PLACE_W-1:0];
                n_bump  = r_bump + bfla_pkg::t_bump'(r_entry_size);
            end else begin
                n_status = bfla_pkg::STATUS_NO_SPACE;
            end
        end
    end

    // Saturating live counters, selected by the entry kind.
    assign count_up = !is_free && !no_space;
    assign count_dn = is_free;

    always_comb begin
        n_nodes = r_nodes;
        n_links = r_links;
        if (r_s1_is_node) begin
            if (count_up && (r_nodes != bfla_pkg::COUNT_MAX)) begin
                n_nodes = r_nodes + 12'd1;
            end else if (count_dn && (r_nodes != '0)) begin
                n_nodes = r_nodes - 12'd1;
            end
        end else begin
            if (count_up && (r_links != bfla_pkg::COUNT_MAX)) begin
                n_links = r_links + 12'd1;
            end else if (count_dn && (r_links != '0)) begin
                n_links = r_links - 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump  <= bfla_pkg::t_bump'(bfla_pkg::ENTRY_SIZE_RST);
            r_nodes <= '0;
            r_links <= '0;
        end else if (s1_fire) begin
            r_bump  <= n_bump;
            r_nodes <= n_nodes;
            r_links <= n_links;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_given  <= n_given;
            r_out_status <= n_status;
        end
    end

    bfla_gap_list u_gap_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gap_ctl),
        .o_stat  (gap_stat)
    );

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.given_place = r_out_given;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.nodes_live  = r_nodes;
    assign o_rsp.links_live  = r_links;

endmodule

`default_nettype wire

// ===== src/bfla_chk.sv =====
`default_nettype none

module bfla_chk (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             i_req_ready,
    input wire logic             i_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire bfla_pkg::t_place i_rsp_given,
    input wire logic             i_rsp_status,
    input wire bfla_pkg::t_count i_rsp_nodes,
    input wire bfla_pkg::t_count i_rsp_links
);

    // A result beat stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result beat dropped before it was taken");

    // A stalled result keeps its payload.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_given) && $stable(i_rsp_status) &&
            $stable(i_rsp_nodes) && $stable(i_rsp_links))
        else $error("stalled result beat changed");

    // A failed allocation never hands out an address.
    a_no_space_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == bfla_pkg::STATUS_NO_SPACE) |->
            (i_rsp_given == '0))
        else $error("no-space result carries an address");

    // With no result pending the block always takes a request.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request refused while the output is empty");

    // Reset leaves no result behind.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result beat shown right after reset");

endmodule

bind bump_and_free_list_allocator bfla_chk u_bfla_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_given  (o_rsp.given_place),
    .i_rsp_status (o_rsp.status),
    .i_rsp_nodes  (o_rsp.nodes_live),
    .i_rsp_links  (o_rsp.links_live)
);

`default_nettype wire

// ===== verif/tb_bump_and_free_list_allocator.sv =====
`timescale 1ns / 100ps

module tb_bump_and_free_list_allocator;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned MAX_REPORTS = 10;

    // One request beat as the sender offers it.
    typedef struct packed {
        bfla_pkg::t_cmd   cmd;
        bfla_pkg::t_place place;
        logic             is_node;
    } t_request;

    // One result beat: the granted place, the status and both live counters.
    typedef struct packed {
        bfla_pkg::t_place  given;
        bfla_pkg::t_status status;
        bfla_pkg::t_count  nodes;
        bfla_pkg::t_count  links;
    } t_grant;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [bfla_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    bfla_pkg::t_cfg_data i_cfg_data;

    bfla_req_if req_bus ();
    bfla_rsp_if rsp_bus ();

    bump_and_free_list_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Allocator state as the testbench expects it.
    bfla_pkg::t_space cfg_space  = bfla_pkg::SPACE_SIZE_RST;
    bfla_pkg::t_entry cfg_entry  = bfla_pkg::ENTRY_SIZE_RST;
    bfla_pkg::t_bump  bump_ptr   = bfla_pkg::t_bump'(bfla_pkg::ENTRY_SIZE_RST);
    bfla_pkg::t_place gap_head   = '0;
    bfla_pkg::t_place gap_link [bfla_pkg::SPACE_WORDS];
    bfla_pkg::t_count node_cnt   = '0;
    bfla_pkg::t_count link_cnt   = '0;

    t_request          pending_reqs[$];
    t_grant            expected_grants[$];
    bfla_pkg::t_place  handed_out[$];

    int unsigned req_beats      = 0;
    int unsigned req_beats_seen = 0;
    bit          offer_open     = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_done     = 0;
    int unsigned wait_left      = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    bit          calm           = 1'b0;

    // Free-running clock, 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Apply one request to the expected state and return the result it gives.
    function automatic t_grant allocate_or_free(bfla_pkg::t_cmd cmd, bfla_pkg::t_place place,
                                                logic is_node);
        t_grant g;
        g = '{given: '0, status: bfla_pkg::STATUS_OK, nodes: '0, links: '0};
        if (cmd == bfla_pkg::CMD_ALLOC) begin
            if (gap_head != '0) begin
                g.given  = gap_head;
                gap_head = gap_link[int'(gap_head) % bfla_pkg::SPACE_WORDS];
            end else if (bump_ptr < bfla_pkg::t_bump'(cfg_space)) begin
                g.given  = bfla_pkg::t_place'(bump_ptr);
                bump_ptr = bump_ptr + bfla_pkg::t_bump'(cfg_entry);
            end else begin
                g.status = bfla_pkg::STATUS_NO_SPACE;
            end
            if (g.status == bfla_pkg::STATUS_OK) begin
                if (is_node) begin
                    if (node_cnt != bfla_pkg::COUNT_MAX) node_cnt = node_cnt + 12'd1;
                end else begin
                    if (link_cnt != bfla_pkg::COUNT_MAX) link_cnt = link_cnt + 12'd1;
                end
                handed_out.push_back(g.given);
            end
        end else begin
            gap_link[int'(place) % bfla_pkg::SPACE_WORDS] = gap_head;
            gap_head = place;
            if (is_node) begin
                if (node_cnt != '0) node_cnt = node_cnt - 12'd1;
            end else begin
                if (link_cnt != '0) link_cnt = link_cnt - 12'd1;
            end
        end
        g.nodes = node_cnt;
        g.links = link_cnt;
        return g;
    endfunction

    function automatic void note_failure(string what);
        if (fail_count < MAX_REPORTS) $display("%0t: %s", $realtime, what);
        fail_count++;
    endfunction

    // Cycle count, calm stretches with no idling, and the run timeout.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 128 == 0) calm = ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check result beats against the oldest expectation, then predict new requests.
    always @(posedge i_clk) begin : track_beats
        t_grant seen;
        t_grant want;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                seen.given  = rsp_bus.given_place;
                seen.status = bfla_pkg::t_status'(rsp_bus.status);
                seen.nodes  = rsp_bus.nodes_live;
                seen.links  = rsp_bus.links_live;
                if (expected_grants.size() == 0) begin
                    note_failure($sformatf("unexpected result beat place=%0d status=%0d",
                                           seen.given, seen.status));
                end else begin
                    want = expected_grants.pop_front();
                    if (seen.given != want.given || seen.status != want.status ||
                        seen.nodes != want.nodes || seen.links != want.links) begin
                        note_failure($sformatf(
                            "exp place=%0d status=%0d nodes=%0d links=%0d, got %0d %0d %0d %0d",
                            want.given, want.status, want.nodes, want.links,
                            seen.given, seen.status, seen.nodes, seen.links));
                    end
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                expected_grants.push_back(allocate_or_free(
                    bfla_pkg::t_cmd'(req_bus.command), req_bus.place, req_bus.is_node));
                req_beats++;
            end
        end
    end

    // Request driver: offers queued beats with random gaps in between.
    always @(negedge i_clk) begin : drive_requests
        t_request item;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (offer_open && req_beats != req_beats_seen) begin
                offer_open     = 1'b0;
                req_beats_seen = req_beats;
            end
            if (!offer_open) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    item = pending_reqs.pop_front();
                    req_bus.command <= item.cmd;
                    req_bus.place   <= item.place;
                    req_bus.is_node <= item.is_node;
                    req_bus.valid   <= 1'b1;
                    offer_open = 1'b1;
                    send_gap   = calm ? 0 : idle_length();
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            wait_left  = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
        end else if (wait_left > 0) begin
            wait_left--;
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0) wait_left = idle_length();
        end
    end

    task automatic queue_request(bfla_pkg::t_cmd cmd, bfla_pkg::t_place place, logic is_node);
        while (pending_reqs.size() >= 4) @(posedge i_clk);
        pending_reqs.push_back('{cmd: cmd, place: place, is_node: is_node});
    endtask

    // Mostly allocations and frees of places handed out earlier; the rest
    // frees of arbitrary places, place zero among them.
    task automatic queue_random_request();
        int unsigned      r;
        int unsigned      pick;
        bfla_pkg::t_place place;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            queue_request(bfla_pkg::CMD_ALLOC, bfla_pkg::t_place'($urandom), 1'($urandom));
        end else if (r < 88 && handed_out.size() != 0) begin
            pick  = $urandom_range(0, handed_out.size() - 1);
            place = handed_out[pick];
            handed_out.delete(pick);
            queue_request(bfla_pkg::CMD_FREE, place, 1'($urandom));
        end else if (r < 97) begin
            queue_request(bfla_pkg::CMD_FREE, bfla_pkg::t_place'($urandom), 1'($urandom));
        end else begin
            queue_request(bfla_pkg::CMD_FREE, '0, 1'($urandom));
        end
    endtask

    // Wait until every queued beat has gone and every result has come back.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || offer_open || expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(bfla_pkg::t_cfg_idx idx, bfla_pkg::t_cfg_data value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bfla_pkg::CFG_SPACE_SIZE) cfg_space = bfla_pkg::t_space'(value);
        else cfg_entry = bfla_pkg::t_entry'(value);
    endtask

    task automatic random_phase(bfla_pkg::t_cfg_data space, bfla_pkg::t_cfg_data entry,
                                int unsigned count, bit with_hold);
        wait_idle();
        write_register(bfla_pkg::CFG_SPACE_SIZE, space);
        write_register(bfla_pkg::CFG_ENTRY_SIZE, entry);
        for (int unsigned i = 0; i < count; i++) begin
            if (with_hold && i == 20) hold_requests++;
            queue_random_request();
        end
    endtask

    initial begin
        req_bus.valid   = 1'b0;
        req_bus.command = bfla_pkg::CMD_ALLOC;
        req_bus.place   = '0;
        req_bus.is_node = 1'b0;
        rsp_bus.ready   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = bfla_pkg::CFG_SPACE_SIZE;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with reset settings: frees at zero counters, top
        // address, place zero hiding the list, a double free, fresh allocations.
        queue_request(bfla_pkg::CMD_FREE, 12'hFFF, 1'b0);
        queue_request(bfla_pkg::CMD_FREE, 12'hAAA, 1'b1);
        queue_request(bfla_pkg::CMD_ALLOC, 12'hFFF, 1'b1);
        queue_request(bfla_pkg::CMD_ALLOC, 12'h000, 1'b0);
        queue_request(bfla_pkg::CMD_ALLOC, 12'h555, 1'b1);
        queue_request(bfla_pkg::CMD_ALLOC, 12'hAAA, 1'b0);
        queue_request(bfla_pkg::CMD_FREE, 12'h555, 1'b1);
        queue_request(bfla_pkg::CMD_FREE, 12'h000, 1'b0);
        queue_request(bfla_pkg::CMD_ALLOC, 12'h000, 1'b1);
        queue_request(bfla_pkg::CMD_FREE, 12'h008, 1'b1);
        queue_request(bfla_pkg::CMD_FREE, 12'h008, 1'b1);
        queue_request(bfla_pkg::CMD_ALLOC, 12'h000, 1'b0);
        queue_request(bfla_pkg::CMD_ALLOC, 12'h000, 1'b1);
        queue_request(bfla_pkg::CMD_FREE, 12'h000, 1'b0);
        queue_request(bfla_pkg::CMD_ALLOC, 12'hFFF, 1'b0);
        queue_request(bfla_pkg::CMD_FREE, 12'h018, 1'b1);

        // Random phases over several settings, extremes included.
        random_phase(12'd4095, 12'd1, 160, 1'b1);
        random_phase(12'd1, 12'd64, 100, 1'b0);
        random_phase(bfla_pkg::t_cfg_data'($urandom_range(1, 4095)),
                     bfla_pkg::t_cfg_data'($urandom_range(1, 64)), 130, 1'b0);
        random_phase(12'd4095, 12'd64, 130, 1'b0);

        // Short closing phase with a mid-range space and the default step.
        random_phase(12'd3000, 12'd8, 20, 1'b0);

        wait_idle();
        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
